FILE: hdl/polyphase_pixel_resampler_top_defines.svh
// Assertion macros used by the resampler sequencer.
`ifndef POLYPHASE_PIXEL_RESAMPLER_TOP_DEFINES_SVH
`define POLYPHASE_PIXEL_RESAMPLER_TOP_DEFINES_SVH

// The condition in pre implies post in the same cycle.
`define PPR_ASSERT_NOW(name, clk_s, rst_s, pre, post) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |-> (post)) \
        else $error("ppr: assertion failed");

// The condition in pre implies post in the next cycle.
`define PPR_ASSERT_NEXT(name, clk_s, rst_s, pre, post) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |=> (post)) \
        else $error("ppr: assertion failed");

`endif

FILE: hdl/ppr_pkg.sv
// Types, constants and helper functions of the polyphase pixel resampler.
package ppr_pkg;

    localparam int MAX_OUT  = 2048;
    localparam int MAX_TAPS = 64;
    localparam int MAX_SRC  = 2048;

    localparam int OP_W      = 2;
    localparam int IDX_W     = 11;
    localparam int TAPIDX_W  = 6;
    localparam int WEIGHT_W  = 16;
    localparam int START_W   = 11;
    localparam int COUNT_W   = 7;
    localparam int PIXEL_W   = 32;
    localparam int FMT_W     = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 2;

    localparam int OUT_AW  = $clog2(MAX_OUT);
    localparam int TAP_AW  = $clog2(MAX_TAPS);
    localparam int SRC_AW  = $clog2(MAX_SRC);
    localparam int W_AW    = OUT_AW + TAP_AW;
    localparam int W_DEPTH = MAX_OUT * MAX_TAPS;
    localparam int REC_W   = START_W + COUNT_W;
    localparam int POS_W   = START_W + 1;
    localparam int PROD_W  = 9 + WEIGHT_W;
    localparam int ACC_W   = PROD_W + TAP_AW + 1;

    localparam logic [ACC_W-1:0] ACC_INIT = ACC_W'(32'h80);

    typedef enum logic [OP_W-1:0] {
        OP_WEIGHT  = 2'd0,
        OP_RECORD  = 2'd1,
        OP_SAMPLE  = 2'd2,
        OP_COMPUTE = 2'd3
    } ppr_op_t;

    localparam logic [FMT_W-1:0] FMT_ARGB = 2'd0;
    localparam logic [FMT_W-1:0] FMT_XRGB = 2'd1;
    localparam logic [FMT_W-1:0] FMT_A8   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FORMAT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UNBOUND = 1'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REC,
        ST_TAP,
        ST_DRAIN,
        ST_FINISH
    } ppr_state_t;

    typedef struct packed {
        logic [OP_W-1:0]            operation;
        logic [IDX_W-1:0]           out_index;
        logic [TAPIDX_W-1:0]        tap_index;
        logic signed [WEIGHT_W-1:0] weight_value;
        logic [START_W-1:0]         window_start;
        logic [COUNT_W-1:0]         tap_count;
        logic [IDX_W-1:0]           sample_index;
        logic [PIXEL_W-1:0]         sample_value;
    } ppr_in_word_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_out;
        logic [IDX_W-1:0]   result_index;
    } ppr_out_word_t;

    typedef struct packed {
        logic accept;
        logic load_rec;
        logic issue;
        logic load_out;
    } ppr_cmd_t;

    typedef struct packed {
        logic compute_req;
        logic rec_zero;
        logic last_tap;
        logic out_free;
    } ppr_status_t;

    // Floor shift by 8, then clamp to 0..hi.
    function automatic logic [7:0] clamp_ch(input logic [ACC_W-1:0] acc,
                                            input logic [7:0] hi);
        logic signed [ACC_W-9:0] v;
        logic signed [ACC_W-9:0] lim;
        logic [7:0]              res;
        v   = $signed(acc[ACC_W-1:8]);
        lim = $signed({{(ACC_W-16){1'b0}}, hi});
        if (v < 0)
            res = 8'd0;
        else if (v > lim)
            res = hi;
        else
            res = v[7:0];
        return res;
    endfunction

endpackage

FILE: hdl/ppr_if.sv
// Valid/ready channel interfaces for resampler input and result words.
interface ppr_in_if;
    logic                              valid;
    logic                              ready;
    logic [ppr_pkg::OP_W-1:0]            operation;
    logic [ppr_pkg::IDX_W-1:0]           out_index;
    logic [ppr_pkg::TAPIDX_W-1:0]        tap_index;
    logic signed [ppr_pkg::WEIGHT_W-1:0] weight_value;
    logic [ppr_pkg::START_W-1:0]         window_start;
    logic [ppr_pkg::COUNT_W-1:0]         tap_count;
    logic [ppr_pkg::IDX_W-1:0]           sample_index;
    logic [ppr_pkg::PIXEL_W-1:0]         sample_value;

    modport source (
        output valid, operation, out_index, tap_index, weight_value,
               window_start, tap_count, sample_index, sample_value,
        input  ready
    );
    modport sink (
        input  valid, operation, out_index, tap_index, weight_value,
               window_start, tap_count, sample_index, sample_value,
        output ready
    );
endinterface

interface ppr_out_if;
    logic                        valid;
    logic                        ready;
    logic [ppr_pkg::PIXEL_W-1:0] pixel_out;
    logic [ppr_pkg::IDX_W-1:0]   result_index;

    modport source (
        output valid, pixel_out, result_index,
        input  ready
    );
    modport sink (
        input  valid, pixel_out, result_index,
        output ready
    );
endinterface

FILE: hdl/ppr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ppr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/ppr_ctrl.sv
// Sequencer of the resampler: accepts words and steps one compute word.
`include "polyphase_pixel_resampler_top_defines.svh"

module ppr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  ppr_pkg::ppr_status_t st,
    output ppr_pkg::ppr_cmd_t    cmd
);

    ppr_pkg::ppr_state_t state_reg;
    ppr_pkg::ppr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ppr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ppr_pkg::ST_IDLE:
            begin
                if (req_valid && st.compute_req)
                    state_next = ppr_pkg::ST_REC;
            end
            ppr_pkg::ST_REC:
            begin
                state_next = st.rec_zero ? ppr_pkg::ST_FINISH : ppr_pkg::ST_TAP;
            end
            ppr_pkg::ST_TAP:
            begin
                if (st.last_tap)
                    state_next = ppr_pkg::ST_DRAIN;
            end
            ppr_pkg::ST_DRAIN:
            begin
                state_next = ppr_pkg::ST_FINISH;
            end
            ppr_pkg::ST_FINISH:
            begin
                if (st.out_free)
                    state_next = ppr_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ppr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready    = 1'b0;
        cmd          = '0;
        case (state_reg)
            ppr_pkg::ST_IDLE:
            begin
                req_ready  = 1'b1;
                cmd.accept = req_valid;
            end
            ppr_pkg::ST_REC:
            begin
                cmd.load_rec = 1'b1;
            end
            ppr_pkg::ST_TAP:
            begin
                cmd.issue = 1'b1;
            end
            ppr_pkg::ST_FINISH:
            begin
                cmd.load_out = st.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    `PPR_ASSERT_NEXT(a_start_compute, clk, rst_n, (state_reg == ppr_pkg::ST_IDLE && req_valid && st.compute_req), (state_reg == ppr_pkg::ST_REC))
    `PPR_ASSERT_NEXT(a_rec_to_taps, clk, rst_n, (state_reg == ppr_pkg::ST_REC && !st.rec_zero), (state_reg == ppr_pkg::ST_TAP))
    `PPR_ASSERT_NEXT(a_tap_exit, clk, rst_n, (state_reg == ppr_pkg::ST_TAP), (state_reg == ppr_pkg::ST_TAP || state_reg == ppr_pkg::ST_DRAIN))

endmodule

FILE: hdl/ppr_datapath.sv
// Datapath of the resampler: stores, tap accumulators and result register.
module ppr_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ppr_pkg::ppr_in_word_t           in_word,
    input  logic                            cfg_write_en,
    input  logic [ppr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ppr_pkg::CFG_W-1:0]       cfg_data,
    input  ppr_pkg::ppr_cmd_t               cmd,
    output ppr_pkg::ppr_status_t            st,
    output logic                            out_valid,
    input  logic                            out_ready,
    output ppr_pkg::ppr_out_word_t          out_word
);

    logic [ppr_pkg::FMT_W-1:0] format_reg;
    logic                      unbound_reg;

    logic                               idx_in_range;
    logic                               we_weight;
    logic                               we_rec;
    logic                               we_sample;
    logic [ppr_pkg::COUNT_W-1:0]        sat_count;
    logic [ppr_pkg::WEIGHT_W-1:0]       weight_rd;
    logic [ppr_pkg::REC_W-1:0]          rec_rd;
    logic [ppr_pkg::PIXEL_W-1:0]        sample_rd;

    logic [ppr_pkg::OUT_AW-1:0]         idx_reg;
    logic [ppr_pkg::START_W-1:0]        first_reg;
    logic [ppr_pkg::COUNT_W-1:0]        taps_reg;
    logic [ppr_pkg::COUNT_W-1:0]        cnt_reg;
    logic [ppr_pkg::COUNT_W-1:0]        cnt_next;
    logic                               issued_reg;
    logic                               oob_reg;
    logic [ppr_pkg::POS_W-1:0]          pos;

    logic [ppr_pkg::ACC_W-1:0]          acc_reg [4];
    logic [7:0]                         lane_byte [4];
    logic signed [ppr_pkg::PROD_W-1:0]  prod [4];
    logic [ppr_pkg::PIXEL_W-1:0]        sample_eff;

    logic [7:0]                         ch_a;
    logic [ppr_pkg::PIXEL_W-1:0]        pixel;

    logic                               out_valid_reg;
    ppr_pkg::ppr_out_word_t             out_word_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg  <= '0;
            unbound_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                ppr_pkg::REG_FORMAT:  format_reg  <= cfg_data[ppr_pkg::FMT_W-1:0];
                ppr_pkg::REG_UNBOUND: unbound_reg <= cfg_data[0];
                default:              format_reg  <= format_reg;
            endcase
        end
    end

    // Store writes happen in the cycle the word is accepted.
    assign idx_in_range = (32'(in_word.out_index) < ppr_pkg::MAX_OUT);
    assign we_weight = cmd.accept && (in_word.operation == ppr_pkg::OP_WEIGHT)
                       && idx_in_range && (32'(in_word.tap_index) < ppr_pkg::MAX_TAPS);
    assign we_rec    = cmd.accept && (in_word.operation == ppr_pkg::OP_RECORD) && idx_in_range;
    assign we_sample = cmd.accept && (in_word.operation == ppr_pkg::OP_SAMPLE)
                       && (32'(in_word.sample_index) < ppr_pkg::MAX_SRC);
    assign sat_count = (32'(in_word.tap_count) > ppr_pkg::MAX_TAPS)
                       ? ppr_pkg::COUNT_W'(ppr_pkg::MAX_TAPS) : in_word.tap_count;

    assign pos = ppr_pkg::POS_W'(first_reg) + ppr_pkg::POS_W'(cnt_reg);

    ppr_ram #(.WIDTH(ppr_pkg::WEIGHT_W), .DEPTH(ppr_pkg::W_DEPTH)) u_weight_ram (
        .clk   (clk),
        .we    (we_weight),
        .waddr ({in_word.out_index[ppr_pkg::OUT_AW-1:0],
                 in_word.tap_index[ppr_pkg::TAP_AW-1:0]}),
        .wdata (in_word.weight_value),
        .raddr ({idx_reg, cnt_reg[ppr_pkg::TAP_AW-1:0]}),
        .rdata (weight_rd)
    );

    ppr_ram #(.WIDTH(ppr_pkg::REC_W), .DEPTH(ppr_pkg::MAX_OUT)) u_record_ram (
        .clk   (clk),
        .we    (we_rec),
        .waddr (in_word.out_index[ppr_pkg::OUT_AW-1:0]),
        .wdata ({in_word.window_start, sat_count}),
        .raddr (in_word.out_index[ppr_pkg::OUT_AW-1:0]),
        .rdata (rec_rd)
    );

    ppr_ram #(.WIDTH(ppr_pkg::PIXEL_W), .DEPTH(ppr_pkg::MAX_SRC)) u_sample_ram (
        .clk   (clk),
        .we    (we_sample),
        .waddr (in_word.sample_index[ppr_pkg::SRC_AW-1:0]),
        .wdata (in_word.sample_value),
        .raddr (pos[ppr_pkg::SRC_AW-1:0]),
        .rdata (sample_rd)
    );

    assign cnt_next = cnt_reg + ppr_pkg::COUNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issued_reg <= 1'b0;
        end
        else
        begin
            issued_reg <= cmd.issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            idx_reg <= in_word.out_index[ppr_pkg::OUT_AW-1:0];
        end
        if (cmd.load_rec)
        begin
            first_reg <= rec_rd[ppr_pkg::REC_W-1:ppr_pkg::COUNT_W];
            taps_reg  <= rec_rd[ppr_pkg::COUNT_W-1:0];
            cnt_reg   <= '0;
        end
        else if (cmd.issue)
        begin
            cnt_reg <= cnt_next;
        end
        oob_reg <= (32'(pos) >= ppr_pkg::MAX_SRC);
    end

    // One tap per cycle: the four lanes multiply the returned sample bytes.
    assign sample_eff = oob_reg ? '0 : sample_rd;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            lane_byte[k] = sample_eff[8*(3-k) +: 8];
        end
        if (format_reg == ppr_pkg::FMT_A8)
        begin
            lane_byte[0] = sample_eff[7:0];
        end
        for (int k = 0; k < 4; k++)
        begin
            prod[k] = $signed({1'b0, lane_byte[k]}) * $signed(weight_rd);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (cmd.load_rec)
                acc_reg[k] <= ppr_pkg::ACC_INIT;
            else if (issued_reg)
                acc_reg[k] <= acc_reg[k] + ppr_pkg::ACC_W'(prod[k]);
        end
    end

    // Final pixel: clamp or keep the low byte of each shifted sum.
    assign ch_a = unbound_reg ? ppr_pkg::clamp_ch(acc_reg[0], 8'hFF) : acc_reg[0][15:8];

    always_comb
    begin
        case (format_reg)
            ppr_pkg::FMT_A8:
            begin
                pixel = {24'd0, ch_a};
            end
            ppr_pkg::FMT_XRGB:
            begin
                if (unbound_reg)
                    pixel = {8'hFF, ppr_pkg::clamp_ch(acc_reg[1], 8'hFF),
                             ppr_pkg::clamp_ch(acc_reg[2], 8'hFF),
                             ppr_pkg::clamp_ch(acc_reg[3], 8'hFF)};
                else
                    pixel = {8'hFF, acc_reg[1][15:8], acc_reg[2][15:8], acc_reg[3][15:8]};
            end
            default:
            begin
                if (unbound_reg)
                    pixel = {ch_a, ppr_pkg::clamp_ch(acc_reg[1], ch_a),
                             ppr_pkg::clamp_ch(acc_reg[2], ch_a),
                             ppr_pkg::clamp_ch(acc_reg[3], ch_a)};
                else
                    pixel = {ch_a, acc_reg[1][15:8], acc_reg[2][15:8], acc_reg[3][15:8]};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_word_reg.pixel_out    <= pixel;
            out_word_reg.result_index <= ppr_pkg::IDX_W'(idx_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    assign st.compute_req = (in_word.operation == ppr_pkg::OP_COMPUTE) && idx_in_range;
    assign st.rec_zero    = (rec_rd[ppr_pkg::COUNT_W-1:0] == '0);
    assign st.last_tap    = (cnt_next == taps_reg);
    assign st.out_free    = !out_valid_reg || out_ready;

endmodule

FILE: hdl/polyphase_pixel_resampler_top.sv
// Top level of the one-dimensional polyphase pixel resampler.
//
//  channel | dir  | word
//  --------+------+----------------------------------------------------------
//  req     | in   | operation, indexes, weight, window record, sample
//  rsp     | out  | pixel_out, result_index (one per in-range compute word)
//  cfg     | in   | pixel_format (index 0), unbound_mode (index 1)
//
// Weight, record and sample words are written in the cycle they are accepted.
// A compute word, taps being tap_count saturated to 64, steps through accept,
// record read, one tap per cycle through the single read port of the
// weight and sample memories, drain, and loading of the result register.
// An empty window skips the taps and the drain.
// rst_n clears the sequencer, the configuration and the result valid; the
// stores are not cleared. A held result does not stall writes, but a following
// compute word waits in its last cycle, and blocks the input, until it is taken.
module polyphase_pixel_resampler_top (
    input  logic                            clk,
    input  logic                            rst_n,
    ppr_in_if.sink                          req,
    ppr_out_if.source                       rsp,
    input  logic                            cfg_write_en,
    input  logic [ppr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ppr_pkg::CFG_W-1:0]       cfg_data
);

    ppr_pkg::ppr_in_word_t  in_word;
    ppr_pkg::ppr_out_word_t out_word;
    ppr_pkg::ppr_cmd_t      cmd;
    ppr_pkg::ppr_status_t   st;
    logic                   ready;
    logic                   out_valid;

    assign in_word.operation    = req.operation;
    assign in_word.out_index    = req.out_index;
    assign in_word.tap_index    = req.tap_index;
    assign in_word.weight_value = req.weight_value;
    assign in_word.window_start = req.window_start;
    assign in_word.tap_count    = req.tap_count;
    assign in_word.sample_index = req.sample_index;
    assign in_word.sample_value = req.sample_value;

    ppr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (ready),
        .st        (st),
        .cmd       (cmd)
    );

    ppr_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_word      (in_word),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .st           (st),
        .out_valid    (out_valid),
        .out_ready    (rsp.ready),
        .out_word     (out_word)
    );

    assign req.ready        = ready;
    assign rsp.valid        = out_valid;
    assign rsp.pixel_out    = out_word.pixel_out;
    assign rsp.result_index = out_word.result_index;

endmodule

FILE: tb/ppr_result_checker.sv
// Checker for the resampler: predicts each result word from the accepted words and compares.
`timescale 1ns / 100ps
module ppr_result_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    ppr_in_if                             req,
    ppr_out_if                            rsp,
    input  logic                          cfg_write_en,
    input  logic [ppr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ppr_pkg::CFG_W-1:0]     cfg_data,
    output int                            error_count,
    output int                            pending
);
    import ppr_pkg::*;

    localparam longint ROUND_HALF   = 128;
    localparam logic [7:0] OPAQUE_ALPHA = 8'hFF;

    logic [WEIGHT_W-1:0] tap_weight [W_DEPTH];
    logic [START_W-1:0]  win_first [MAX_OUT];
    logic [COUNT_W-1:0]  win_taps [MAX_OUT];
    logic [PIXEL_W-1:0]  src_line [MAX_SRC];
    logic [FMT_W-1:0]    fmt;
    logic                unb;

    ppr_out_word_t pixels_due [$];
    ppr_out_word_t due;
    int            mismatches;

    function automatic logic [7:0] clip_channel(input longint v, input longint ceiling);
        logic [7:0] res;
        if (v < 0)
            res = 8'd0;
        else if (v > ceiling)
            res = 8'(ceiling);
        else
            res = 8'(v);
        return res;
    endfunction

    // Accumulates each channel separately, then wraps or clamps per the mode.
    function automatic ppr_out_word_t resample_pixel(input logic [IDX_W-1:0] oi);
        longint             acc [4];
        logic [7:0]         ch [4];
        logic [PIXEL_W-1:0] smp;
        longint             w;
        int                 pos;
        ppr_out_word_t      res;
        for (int k = 0; k < 4; k++)
            acc[k] = ROUND_HALF;
        for (int i = 0; i < int'(win_taps[oi]); i++)
        begin
            pos = int'(win_first[oi]) + i;
            smp = (pos < MAX_SRC) ? src_line[pos] : '0;
            w = longint'($signed(tap_weight[int'(oi) * MAX_TAPS + i]));
            if (fmt == FMT_A8)
            begin
                acc[0] += longint'(smp[7:0]) * w;
            end
            else
            begin
                acc[0] += longint'(smp[31:24]) * w;
                acc[1] += longint'(smp[23:16]) * w;
                acc[2] += longint'(smp[15:8]) * w;
                acc[3] += longint'(smp[7:0]) * w;
            end
        end
        for (int k = 0; k < 4; k++)
            ch[k] = unb ? clip_channel(acc[k] >>> 8, 255) : 8'(acc[k] >>> 8);
        case (fmt)
            FMT_A8:
                res.pixel_out = {24'd0, ch[0]};
            FMT_XRGB:
                res.pixel_out = {OPAQUE_ALPHA, ch[1], ch[2], ch[3]};
            default:
            begin
                // Premultiplied colors may not exceed the clamped alpha.
                if (unb)
                    for (int k = 1; k < 4; k++)
                        ch[k] = clip_channel(acc[k] >>> 8, longint'(ch[0]));
                res.pixel_out = {ch[0], ch[1], ch[2], ch[3]};
            end
        endcase
        res.result_index = oi;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixels_due.delete();
            fmt = FMT_ARGB;
            unb = 1'b0;
            mismatches = 0;
        end
        else
        begin
            // A result word can only belong to an older compute word.
            if (rsp.valid && rsp.ready)
            begin
                if (pixels_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected word, expected none, actual pixel %h index %0d",
                             $time, rsp.pixel_out, rsp.result_index);
                end
                else
                begin
                    due = pixels_due.pop_front();
                    if (rsp.pixel_out !== due.pixel_out)
                    begin
                        mismatches++;
                        $display("%0t: pixel_out of index %0d, expected %h, actual %h",
                                 $time, due.result_index, due.pixel_out, rsp.pixel_out);
                    end
                    if (rsp.result_index !== due.result_index)
                    begin
                        mismatches++;
                        $display("%0t: result_index, expected %0d, actual %0d",
                                 $time, due.result_index, rsp.result_index);
                    end
                end
            end
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_FORMAT:  fmt = cfg_data[FMT_W-1:0];
                    REG_UNBOUND: unb = cfg_data[0];
                    default: ;
                endcase
            end
            if (req.valid && req.ready)
            begin
                case (ppr_op_t'(req.operation))
                    OP_SAMPLE:
                        if (int'(req.sample_index) < MAX_SRC)
                            src_line[req.sample_index] = req.sample_value;
                    OP_WEIGHT:
                        if (int'(req.out_index) < MAX_OUT && int'(req.tap_index) < MAX_TAPS)
                            tap_weight[int'(req.out_index) * MAX_TAPS + int'(req.tap_index)] =
                                req.weight_value;
                    OP_RECORD:
                        if (int'(req.out_index) < MAX_OUT)
                        begin
                            win_first[req.out_index] = req.window_start;
                            win_taps[req.out_index] = (int'(req.tap_count) > MAX_TAPS) ?
                                COUNT_W'(MAX_TAPS) : req.tap_count;
                        end
                    default:
                        if (int'(req.out_index) < MAX_OUT)
                            pixels_due.push_back(resample_pixel(req.out_index));
                endcase
            end
        end
        error_count <= mismatches;
        pending <= pixels_due.size();
    end

endmodule

FILE: tb/polyphase_pixel_resampler_top_test.sv
// Testbench top: stimulus, pacing, configuration phases and verdict for the resampler.
`timescale 1ns / 100ps
module polyphase_pixel_resampler_top_test;
    import ppr_pkg::*;

    typedef enum int {
        PACE_FREE,
        PACE_SRC_GAPS,
        PACE_SINK_STALLS,
        PACE_BOTH
    } pace_t;

    localparam logic [FMT_W-1:0] FMT_SPARE = 2'd3;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 138;
    localparam int SETTLE_CYCLES   = 80;
    localparam int QUIET_LIMIT     = 4000;
    localparam int BUSY_PCT        = 68;
    localparam int LIGHT_PCT       = 13;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   error_count;
    int                   pending;
    int                   gap_pct;
    int                   stall_pct;
    int                   words_sent;

    // What has been written so far, so that no unwritten entry is ever read.
    bit                  src_seen [MAX_SRC];
    bit                  rec_seen [MAX_OUT];
    int                  rec_start [MAX_OUT];
    int                  rec_taps [MAX_OUT];
    bit [MAX_TAPS-1:0]   wt_seen [MAX_OUT];
    int                  ready_rows [$];

    ppr_in_if  req ();
    ppr_out_if rsp ();

    polyphase_pixel_resampler_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .rsp          (rsp),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    ppr_result_checker pixel_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .rsp          (rsp),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .error_count  (error_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
        rsp.ready <= ($urandom_range(99) >= stall_pct);

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("polyphase_pixel_resampler_top_test: done, errors");
        $finish;
    end

    function automatic ppr_in_word_t any_word();
        ppr_in_word_t w;
        w.operation    = OP_W'($urandom_range(3));
        w.out_index    = IDX_W'($urandom);
        w.tap_index    = TAPIDX_W'($urandom);
        w.weight_value = WEIGHT_W'($urandom);
        w.window_start = START_W'($urandom);
        w.tap_count    = COUNT_W'($urandom);
        w.sample_index = IDX_W'($urandom);
        w.sample_value = $urandom;
        return w;
    endfunction

    function automatic logic [PIXEL_W-1:0] random_pixel();
        logic [PIXEL_W-1:0] p;
        case ($urandom_range(9))
            0:       p = '0;
            1:       p = '1;
            default: p = $urandom;
        endcase
        return p;
    endfunction

    function automatic bit row_complete(input int oi);
        bit ok;
        int pos;
        ok = rec_seen[oi];
        for (int i = 0; ok && i < rec_taps[oi]; i++)
        begin
            pos = rec_start[oi] + i;
            if (!wt_seen[oi][i] || (pos < MAX_SRC && !src_seen[pos]))
                ok = 1'b0;
        end
        return ok;
    endfunction

    // Offers one word; returns at the rising edge where it was taken.
    task automatic put_word(input ppr_in_word_t w);
        if ($urandom_range(99) < gap_pct)
        begin
            req.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < gap_pct);
        end
        req.valid        <= 1'b1;
        req.operation    <= w.operation;
        req.out_index    <= w.out_index;
        req.tap_index    <= w.tap_index;
        req.weight_value <= w.weight_value;
        req.window_start <= w.window_start;
        req.tap_count    <= w.tap_count;
        req.sample_index <= w.sample_index;
        req.sample_value <= w.sample_value;
        do @(negedge clk); while (!req.ready);
        @(posedge clk);
        words_sent++;
        case (ppr_op_t'(w.operation))
            OP_WEIGHT:
                wt_seen[w.out_index][w.tap_index] = 1'b1;
            OP_RECORD:
            begin
                rec_seen[w.out_index] = 1'b1;
                rec_start[w.out_index] = int'(w.window_start);
                rec_taps[w.out_index] = (int'(w.tap_count) > MAX_TAPS) ?
                    MAX_TAPS : int'(w.tap_count);
            end
            OP_SAMPLE:
                src_seen[w.sample_index] = 1'b1;
            default: ;
        endcase
    endtask

    task automatic send_weight(input int oi, input int ti, input int wv);
        ppr_in_word_t w;
        w = any_word();
        w.operation    = OP_WEIGHT;
        w.out_index    = IDX_W'(oi);
        w.tap_index    = TAPIDX_W'(ti);
        w.weight_value = WEIGHT_W'(wv);
        put_word(w);
    endtask

    task automatic send_record(input int oi, input int start, input int tc);
        ppr_in_word_t w;
        w = any_word();
        w.operation    = OP_RECORD;
        w.out_index    = IDX_W'(oi);
        w.window_start = START_W'(start);
        w.tap_count    = COUNT_W'(tc);
        put_word(w);
    endtask

    task automatic send_sample(input int si, input logic [PIXEL_W-1:0] sv);
        ppr_in_word_t w;
        w = any_word();
        w.operation    = OP_SAMPLE;
        w.sample_index = IDX_W'(si);
        w.sample_value = sv;
        put_word(w);
    endtask

    task automatic send_compute(input int oi);
        ppr_in_word_t w;
        w = any_word();
        w.operation = OP_COMPUTE;
        w.out_index = IDX_W'(oi);
        put_word(w);
    endtask

    task automatic try_compute(input int oi);
        if (row_complete(oi))
            send_compute(oi);
        else
            send_sample($urandom_range(MAX_SRC - 1), random_pixel());
    endtask

    // Sets up one output position from scratch and computes it once or twice.
    task automatic build_row();
        int oi;
        int tc;
        int taps;
        int start;
        int row_sum;
        int wv;
        int pos;
        bit normalized;
        oi = $urandom_range(MAX_OUT - 1);
        case ($urandom_range(49))
            0, 1:    tc = 0;
            2:       tc = $urandom_range(127, MAX_TAPS + 1);
            3:       tc = $urandom_range(MAX_TAPS, 16);
            default: tc = $urandom_range(8, 1);
        endcase
        taps = (tc > MAX_TAPS) ? MAX_TAPS : tc;
        case ($urandom_range(9))
            0:       start = $urandom_range(MAX_SRC - 1, MAX_SRC - 8);
            1, 2:    start = $urandom_range(MAX_SRC - 1);
            default: start = $urandom_range(255);
        endcase
        for (int i = 0; i < taps; i++)
        begin
            pos = start + i;
            if (pos < MAX_SRC && (!src_seen[pos] || $urandom_range(3) == 0))
                send_sample(pos, random_pixel());
        end
        send_record(oi, start, tc);
        row_sum = 0;
        normalized = $urandom_range(1);
        for (int i = 0; i < taps; i++)
        begin
            // A normalized row sums to one in 8.8, with some negative lobes.
            if (normalized)
                wv = (i == taps - 1) ? 256 - row_sum : int'($urandom_range(320)) - 96;
            else
                wv = int'($urandom_range(16'hFFFF));
            row_sum += wv;
            send_weight(oi, i, wv);
        end
        repeat ($urandom_range(2, 1))
        begin
            pos = start + ((taps > 0) ? $urandom_range(taps - 1) : 0);
            if (pos < MAX_SRC && $urandom_range(1))
                send_sample(pos, random_pixel());
            send_compute(oi);
        end
        ready_rows.push_back(oi);
    endtask

    task automatic wait_idle();
        req.valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [FMT_W-1:0] fmt, input logic unb);
        cfg_write_en <= 1'b1;
        cfg_index    <= REG_FORMAT;
        cfg_data     <= CFG_W'(fmt);
        @(posedge clk);
        cfg_index    <= REG_UNBOUND;
        cfg_data     <= CFG_W'(unb);
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic set_pace(input pace_t pace);
        case (pace)
            PACE_SRC_GAPS:
            begin
                gap_pct = BUSY_PCT;
                stall_pct <= 0;
            end
            PACE_SINK_STALLS:
            begin
                gap_pct = 0;
                stall_pct <= BUSY_PCT;
            end
            PACE_BOTH:
            begin
                gap_pct = LIGHT_PCT;
                stall_pct <= LIGHT_PCT;
            end
            default:
            begin
                gap_pct = 0;
                stall_pct <= 0;
            end
        endcase
    endtask

    task automatic send_directed();
        // Empty window.
        send_record(0, 0, 0);
        send_compute(0);
        // Extreme weights, with half the window past the end of the line.
        send_sample(MAX_SRC - 2, 32'hFFFF_FFFF);
        send_sample(MAX_SRC - 1, 32'h0000_0000);
        send_record(MAX_OUT - 1, MAX_SRC - 2, 4);
        send_weight(MAX_OUT - 1, 0, 32767);
        send_weight(MAX_OUT - 1, 1, -32768);
        send_weight(MAX_OUT - 1, 2, 256);
        send_weight(MAX_OUT - 1, 3, -1);
        send_weight(MAX_OUT - 1, MAX_TAPS - 1, 128);
        send_compute(MAX_OUT - 1);
        // Plain two-tap average.
        send_sample(0, 32'h80FF_4020);
        send_sample(1, 32'h7F00_10FF);
        send_record(1, 0, 2);
        send_weight(1, 0, 128);
        send_weight(1, 1, 128);
        send_compute(1);
        ready_rows.push_back(0);
        ready_rows.push_back(1);
        ready_rows.push_back(MAX_OUT - 1);
    endtask

    initial
    begin
        logic [FMT_W-1:0] fmt;
        rst_n            <= 1'b0;
        req.valid        <= 1'b0;
        req.operation    <= '0;
        req.out_index    <= '0;
        req.tap_index    <= '0;
        req.weight_value <= '0;
        req.window_start <= '0;
        req.tap_count    <= '0;
        req.sample_index <= '0;
        req.sample_value <= '0;
        cfg_write_en     <= 1'b0;
        cfg_index        <= '0;
        cfg_data         <= '0;
        stall_pct        <= 0;
        gap_pct = 0;
        words_sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        for (int p = 0; p < PHASES; p++)
        begin
            // Every setting is applied while nothing is in flight.
            wait_idle();
            case (p % 4)
                0:       fmt = FMT_ARGB;
                1:       fmt = FMT_XRGB;
                2:       fmt = FMT_A8;
                default: fmt = FMT_SPARE;
            endcase
            set_config(fmt, (p / 4) == 1);
            set_pace(pace_t'((p + p / 4) % 4));
            if (p == 0)
                send_directed();
            try_compute(0);
            try_compute(1);
            try_compute(MAX_OUT - 1);
            while (words_sent < (p + 1) * ITEMS_PER_PHASE)
            begin
                case ($urandom_range(49))
                    0:
                        wait_idle();
                    1, 2, 3, 4, 5, 6, 7, 8, 9, 10:
                        try_compute(ready_rows[$urandom_range(ready_rows.size() - 1)]);
                    11, 12, 13:
                        send_sample($urandom_range(MAX_SRC - 1), random_pixel());
                    14, 15, 16:
                        send_weight($urandom_range(MAX_OUT - 1), $urandom_range(MAX_TAPS - 1),
                                    int'($urandom_range(16'hFFFF)));
                    17, 18:
                        send_record($urandom_range(MAX_OUT - 1), $urandom_range(MAX_SRC - 1),
                                    $urandom_range(127));
                    default:
                        build_row();
                endcase
            end
        end
        wait_idle();
        if (error_count == 0)
            $display("polyphase_pixel_resampler_top_test: done, clean");
        else
            $display("polyphase_pixel_resampler_top_test: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/ppr_pkg.sv
hdl/ppr_if.sv
hdl/ppr_ram.sv
hdl/ppr_ctrl.sv
hdl/ppr_datapath.sv
hdl/polyphase_pixel_resampler_top.sv
tb/ppr_result_checker.sv
tb/polyphase_pixel_resampler_top_test.sv
